// ===== sv/grcd_pkg.sv =====
// Shared types, constants and command/status structs for the grid ray caster.
`timescale 1ns / 1ps
package grcd_pkg;

   localparam int MapDimDefault = 64;
   localparam int FracBits      = 16;
   localparam int VecFrac       = 14;
   localparam int RecipShift    = 46;

   localparam int PosW      = 22;
   localparam int VecW      = 16;
   localparam int SwW       = 13;
   localparam int MwW       = 7;
   localparam int ColW      = 12;
   localparam int CellAddrW = 12;
   localparam int DistW     = 24;
   localparam int HitW      = 6;
   localparam int CsrAddrW  = 5;
   localparam int CsrDataW  = 32;

   // shared divider: 47-bit dividend, 31-bit divisor
   localparam int DivNW = RecipShift + 1;
   localparam int DivDW = 31;
   localparam int CamW  = 32;
   localparam int RayW  = 32;
   localparam int ProdW = VecW + CamW;

   localparam logic [DistW-1:0] DistMax = '1;

   // configuration register indexes
   localparam logic [2:0] REG_POS_X    = 3'd0;
   localparam logic [2:0] REG_POS_Y    = 3'd1;
   localparam logic [2:0] REG_DIR_X    = 3'd2;
   localparam logic [2:0] REG_DIR_Y    = 3'd3;
   localparam logic [2:0] REG_PLANE_X  = 3'd4;
   localparam logic [2:0] REG_PLANE_Y  = 3'd5;
   localparam logic [2:0] REG_SCREEN_W = 3'd6;
   localparam logic [2:0] REG_MAP_W    = 3'd7;

   typedef logic [2:0] div_op_type;
   localparam div_op_type DIV_CAM  = 3'd0;
   localparam div_op_type DIV_DX   = 3'd1;
   localparam div_op_type DIV_DY   = 3'd2;
   localparam div_op_type DIV_SX   = 3'd3;
   localparam div_op_type DIV_SY   = 3'd4;
   localparam div_op_type DIV_PERP = 3'd5;

   typedef struct packed {
      logic [PosW-1:0]        pos_x;
      logic [PosW-1:0]        pos_y;
      logic signed [VecW-1:0] dir_x;
      logic signed [VecW-1:0] dir_y;
      logic signed [VecW-1:0] plane_x;
      logic signed [VecW-1:0] plane_y;
      logic [SwW-1:0]         screen_width;
      logic [MwW-1:0]         map_width;
   } cfg_type;

   typedef struct packed {
      logic       clr_step;
      logic       map_we;
      logic       load_col;
      logic       div_start;
      div_op_type div_op;
      logic       mul;
      logic       ray;
      logic       walk_step;
      logic       walk_chk;
      logic       out_load;
      logic       out_hit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic ray_zero;
      logic in_map;
      logic wall;
      logic steps_done;
   } stat_type;

endpackage

// ===== sv/grcd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module grcd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   logic [WIDTH-1:0] rdata_in;

   assign rdata_in = re ? mem[raddr] : rdata_ff;
   assign rdata    = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= rdata_in;
   end
endmodule

// ===== sv/grcd_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module grcd_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [grcd_pkg::DivNW-1:0] dividend,
   input  logic [grcd_pkg::DivDW-1:0] divisor,
   output logic                       done,
   output logic [grcd_pkg::DivNW-1:0] quotient
);
   localparam int NW   = grcd_pkg::DivNW;
   localparam int DW   = grcd_pkg::DivDW;
   localparam int CntW = $clog2(NW + 1);

   logic [DW-1:0]   rem_ff, rem_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic [DW:0]     trial;
   logic [DW:0]     diff;
   logic            ge;

   assign trial = {rem_ff, quo_ff[NW-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CntW'(NW);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
         quo_in  = {quo_ff[NW-2:0], ge};
         cnt_in  = cnt_ff - CntW'(1);
         done_in = cnt_ff == CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== sv/grcd_dp.sv =====
// Datapath: wall map, shared divider, ray setup, DDA walk and result registers.
`timescale 1ns / 1ps
module grcd_dp #(
   parameter int MAP_DIM = grcd_pkg::MapDimDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  grcd_pkg::cfg_type              cfg_i,
   input  grcd_pkg::cmd_type              cmd_i,
   output grcd_pkg::stat_type             stat_o,
   input  logic [grcd_pkg::ColW-1:0]      column_i,
   input  logic [grcd_pkg::CellAddrW-1:0] cell_addr_i,
   input  logic                           cell_wall_i,
   output logic [grcd_pkg::DistW-1:0]     perp_dist_o,
   output logic                           hit_side_o,
   output logic [grcd_pkg::HitW-1:0]      hit_x_o,
   output logic [grcd_pkg::HitW-1:0]      hit_y_o,
   output logic                           hit_found_o
);
   localparam int MapCells = MAP_DIM * MAP_DIM;
   localparam int AddrW    = $clog2(MapCells);
   localparam int CoordW   = $clog2(2 * MAP_DIM + 64) + 2;
   localparam int LinW     = CoordW + grcd_pkg::MwW + 1;
   localparam int CntW     = $clog2(2 * MAP_DIM) + 1;
   localparam int SideW    = grcd_pkg::DivNW + CntW;
   localparam int NumW     = CoordW + grcd_pkg::FracBits + 2;
   localparam int FB       = grcd_pkg::FracBits;
   localparam int NW       = grcd_pkg::DivNW;
   localparam int DW       = grcd_pkg::DivDW;
   localparam int FracW    = FB + 1;
   localparam logic [FracW-1:0] One = FracW'(1) << FB;

   // ---- clearing pass and map writes
   logic [AddrW-1:0] clr_ff, clr_in;
   logic [LinW-1:0]  cell_lin;
   logic             cell_ok;
   logic             ram_we;
   logic [AddrW-1:0] ram_waddr;
   logic             ram_wdata;
   logic             ram_rdata;

   assign clr_in    = cmd_i.clr_step ? clr_ff + AddrW'(1) : clr_ff;
   assign cell_lin  = LinW'(cell_addr_i);
   assign cell_ok   = cell_lin < LinW'(MapCells);
   assign ram_we    = cmd_i.clr_step | (cmd_i.map_we & cell_ok);
   assign ram_waddr = cmd_i.clr_step ? clr_ff : cell_lin[AddrW-1:0];
   assign ram_wdata = cmd_i.clr_step ? 1'b0 : cell_wall_i;

   // ---- ray setup
   logic [grcd_pkg::ColW-1:0]   col_ff, col_in;
   logic signed [grcd_pkg::CamW-1:0]  cam_ff, cam_in;
   logic signed [grcd_pkg::ProdW-1:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic signed [grcd_pkg::RayW-1:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic signed [grcd_pkg::RayW-1:0]  rx_neg, ry_neg;
   logic [DW-1:0]    ax, ay;
   logic [FracW-1:0] fx, fy;
   logic [FB-1:0]    frac_x, frac_y;
   logic [grcd_pkg::SwW-1:0] sw_eff;

   assign rx_neg = -rx_ff;
   assign ry_neg = -ry_ff;
   assign ax     = rx_ff[grcd_pkg::RayW-1] ? rx_neg[DW-1:0] : rx_ff[DW-1:0];
   assign ay     = ry_ff[grcd_pkg::RayW-1] ? ry_neg[DW-1:0] : ry_ff[DW-1:0];
   assign frac_x = cfg_i.pos_x[FB-1:0];
   assign frac_y = cfg_i.pos_y[FB-1:0];
   assign fx     = rx_ff[grcd_pkg::RayW-1] ? FracW'(frac_x) : One - FracW'(frac_x);
   assign fy     = ry_ff[grcd_pkg::RayW-1] ? FracW'(frac_y) : One - FracW'(frac_y);
   assign sw_eff = (cfg_i.screen_width == '0) ? grcd_pkg::SwW'(1) : cfg_i.screen_width;

   // ---- walk state
   logic [NW-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [SideW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CoordW-1:0] mx_ff, mx_in, my_ff, my_in;
   logic             side_ff, side_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             take_x;
   logic [LinW-1:0]  walk_lin;
   logic             in_map;

   assign take_x   = (ax != '0) && ((ay == '0) || (sx_ff < sy_ff));
   assign walk_lin = LinW'($unsigned(mx_ff))
                     + LinW'($unsigned(my_ff)) * LinW'(cfg_i.map_width);
   assign in_map   = !mx_ff[CoordW-1] && !my_ff[CoordW-1]
                     && (LinW'($unsigned(mx_ff)) < LinW'(cfg_i.map_width))
                     && (walk_lin < LinW'(MapCells));

   // ---- perpendicular distance numerator
   logic signed [CoordW:0]  edge_c;
   logic [grcd_pkg::PosW-1:0] pos_sel;
   logic signed [NumW-1:0]  num;
   logic signed [NumW-1:0]  num_neg;
   logic [NumW-1:0]         num_mag;

   always_comb begin
      if (side_ff) begin
         edge_c  = (CoordW+1)'(my_ff) + (CoordW+1)'(ry_ff[grcd_pkg::RayW-1]);
         pos_sel = cfg_i.pos_y;
      end else begin
         edge_c  = (CoordW+1)'(mx_ff) + (CoordW+1)'(rx_ff[grcd_pkg::RayW-1]);
         pos_sel = cfg_i.pos_x;
      end
   end

   assign num     = (NumW'(edge_c) <<< FB) - $signed(NumW'(pos_sel));
   assign num_neg = -num;
   assign num_mag = num[NumW-1] ? num_neg : num;

   // ---- divider operand selection
   logic          div_done;
   logic [NW-1:0] quo;
   logic [NW-1:0] dividend;
   logic [DW-1:0] divisor;

   always_comb begin
      unique case (cmd_i.div_op)
         grcd_pkg::DIV_CAM: begin
            dividend = NW'(col_ff) << (FB + 1);
            divisor  = DW'(sw_eff);
         end
         grcd_pkg::DIV_DX: begin
            dividend = NW'(1) << grcd_pkg::RecipShift;
            divisor  = ax;
         end
         grcd_pkg::DIV_DY: begin
            dividend = NW'(1) << grcd_pkg::RecipShift;
            divisor  = ay;
         end
         grcd_pkg::DIV_SX: begin
            dividend = NW'(fx) << (grcd_pkg::RecipShift - FB);
            divisor  = ax;
         end
         grcd_pkg::DIV_SY: begin
            dividend = NW'(fy) << (grcd_pkg::RecipShift - FB);
            divisor  = ay;
         end
         default: begin
            dividend = NW'(num_mag) << grcd_pkg::VecFrac;
            divisor  = side_ff ? ay : ax;
         end
      endcase
   end

   grcd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd_i.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quo)
   );

   // ---- results
   logic [grcd_pkg::DistW-1:0] perp_ff, perp_in;
   logic [grcd_pkg::DistW-1:0] rsp_perp_ff, rsp_perp_in;
   logic                       rsp_side_ff, rsp_side_in;
   logic [grcd_pkg::HitW-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                       rsp_found_ff, rsp_found_in;

   always_comb begin
      col_in    = cmd_i.load_col ? column_i : col_ff;
      cam_in    = cam_ff;
      prod_x_in = prod_x_ff;
      prod_y_in = prod_y_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      side_in   = side_ff;
      cnt_in    = cnt_ff;
      perp_in   = perp_ff;

      if (div_done) begin
         unique case (cmd_i.div_op)
            grcd_pkg::DIV_CAM:
               cam_in = $signed(quo[grcd_pkg::CamW-1:0])
                        - $signed(grcd_pkg::CamW'(One));
            grcd_pkg::DIV_DX: dx_in = quo;
            grcd_pkg::DIV_DY: dy_in = quo;
            grcd_pkg::DIV_SX: sx_in = SideW'(quo);
            grcd_pkg::DIV_SY: sy_in = SideW'(quo);
            default:
               perp_in = (quo > NW'(grcd_pkg::DistMax)) ? grcd_pkg::DistMax
                                                         : quo[grcd_pkg::DistW-1:0];
         endcase
      end

      if (cmd_i.mul) begin
         prod_x_in = cfg_i.plane_x * cam_ff;
         prod_y_in = cfg_i.plane_y * cam_ff;
      end

      if (cmd_i.ray) begin
         // floor shift of the plane term, then add direction
         rx_in   = grcd_pkg::RayW'(cfg_i.dir_x) + grcd_pkg::RayW'(prod_x_ff >>> FB);
         ry_in   = grcd_pkg::RayW'(cfg_i.dir_y) + grcd_pkg::RayW'(prod_y_ff >>> FB);
         mx_in   = $signed(CoordW'(cfg_i.pos_x[grcd_pkg::PosW-1:FB]));
         my_in   = $signed(CoordW'(cfg_i.pos_y[grcd_pkg::PosW-1:FB]));
         side_in = 1'b0;
         cnt_in  = '0;
      end

      if (cmd_i.walk_step) begin
         cnt_in = cnt_ff + CntW'(1);
         if (take_x) begin
            sx_in   = sx_ff + SideW'(dx_ff);
            mx_in   = rx_ff[grcd_pkg::RayW-1] ? mx_ff - CoordW'(1) : mx_ff + CoordW'(1);
            side_in = 1'b0;
         end else begin
            sy_in   = sy_ff + SideW'(dy_ff);
            my_in   = ry_ff[grcd_pkg::RayW-1] ? my_ff - CoordW'(1) : my_ff + CoordW'(1);
            side_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_perp_in  = rsp_perp_ff;
      rsp_side_in  = rsp_side_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_found_in = rsp_found_ff;
      if (cmd_i.out_load) begin
         rsp_found_in = cmd_i.out_hit;
         if (cmd_i.out_hit) begin
            rsp_perp_in = perp_ff;
            rsp_side_in = side_ff;
            rsp_x_in    = mx_ff[grcd_pkg::HitW-1:0];
            rsp_y_in    = my_ff[grcd_pkg::HitW-1:0];
         end else begin
            rsp_perp_in = '0;
            rsp_side_in = 1'b0;
            rsp_x_in    = '0;
            rsp_y_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
      col_ff       <= col_in;
      cam_ff       <= cam_in;
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      side_ff      <= side_in;
      cnt_ff       <= cnt_in;
      perp_ff      <= perp_in;
      rsp_perp_ff  <= rsp_perp_in;
      rsp_side_ff  <= rsp_side_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_found_ff <= rsp_found_in;
   end

   grcd_ram #(
      .WIDTH (1),
      .DEPTH (MapCells)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd_i.walk_chk),
      .raddr (walk_lin[AddrW-1:0]),
      .rdata (ram_rdata)
   );

   assign stat_o.clr_last   = clr_ff == '1;
   assign stat_o.div_done   = div_done;
   assign stat_o.ray_zero   = (ax == '0) && (ay == '0);
   assign stat_o.in_map     = in_map;
   assign stat_o.wall       = ram_rdata;
   assign stat_o.steps_done = cnt_ff == CntW'(2 * MAP_DIM);

   assign perp_dist_o = rsp_perp_ff;
   assign hit_side_o  = rsp_side_ff;
   assign hit_x_o     = rsp_x_ff;
   assign hit_y_o     = rsp_y_ff;
   assign hit_found_o = rsp_found_ff;
endmodule

// ===== sv/grcd_ctrl.sv =====
// Controller: sequences map clearing, cell writes and the ray cast steps.
`timescale 1ns / 1ps
module grcd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_kind,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  grcd_pkg::stat_type stat_i,
   output grcd_pkg::cmd_type  cmd_o
);
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CAM   = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_RAY   = 4'd4;
   localparam logic [3:0] S_DX    = 4'd5;
   localparam logic [3:0] S_DY    = 4'd6;
   localparam logic [3:0] S_SX    = 4'd7;
   localparam logic [3:0] S_SY    = 4'd8;
   localparam logic [3:0] S_STEP  = 4'd9;
   localparam logic [3:0] S_CHK   = 4'd10;
   localparam logic [3:0] S_TEST  = 4'd11;
   localparam logic [3:0] S_PERP  = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       go_ff, go_in;
   logic       hit_ff, hit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       in_div, next_div;

   assign in_div   = (state_ff == S_CAM) || (state_ff == S_DX) || (state_ff == S_DY)
                     || (state_ff == S_SX) || (state_ff == S_SY) || (state_ff == S_PERP);
   assign next_div = (state_in == S_CAM) || (state_in == S_DX) || (state_in == S_DY)
                     || (state_in == S_SX) || (state_in == S_SY) || (state_in == S_PERP);
   assign go_in    = next_div && (state_in != state_ff);

   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      cmd_o    = '0;
      cmd_o.div_start = go_ff & in_div;
      cmd_o.div_op    = grcd_pkg::DIV_CAM;

      unique case (state_ff)
         S_CLEAR: begin
            cmd_o.clr_step = 1'b1;
            if (stat_i.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind) begin
                  cmd_o.load_col = 1'b1;
                  state_in       = S_CAM;
               end else begin
                  cmd_o.map_we = 1'b1;
               end
            end
         end
         S_CAM: begin
            cmd_o.div_op = grcd_pkg::DIV_CAM;
            if (stat_i.div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd_o.mul = 1'b1;
            state_in  = S_RAY;
         end
         S_RAY: begin
            cmd_o.ray = 1'b1;
            state_in  = S_DX;
         end
         S_DX: begin
            cmd_o.div_op = grcd_pkg::DIV_DX;
            if (stat_i.div_done) begin
               state_in = S_DY;
            end
         end
         S_DY: begin
            cmd_o.div_op = grcd_pkg::DIV_DY;
            if (stat_i.div_done) begin
               state_in = S_SX;
            end
         end
         S_SX: begin
            cmd_o.div_op = grcd_pkg::DIV_SX;
            if (stat_i.div_done) begin
               state_in = S_SY;
            end
         end
         S_SY: begin
            cmd_o.div_op = grcd_pkg::DIV_SY;
            if (stat_i.div_done) begin
               hit_in   = 1'b0;
               state_in = stat_i.ray_zero ? S_DONE : S_STEP;
            end
         end
         S_STEP: begin
            cmd_o.walk_step = 1'b1;
            state_in        = S_CHK;
         end
         S_CHK: begin
            cmd_o.walk_chk = 1'b1;
            state_in       = stat_i.in_map ? S_TEST : S_DONE;
         end
         S_TEST: begin
            priority if (stat_i.wall) begin
               hit_in   = 1'b1;
               state_in = S_PERP;
            end else if (stat_i.steps_done) begin
               state_in = S_DONE;
            end else begin
               state_in = S_STEP;
            end
         end
         S_PERP: begin
            cmd_o.div_op = grcd_pkg::DIV_PERP;
            if (stat_i.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd_o.out_load = 1'b1;
               cmd_o.out_hit  = hit_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd_o.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         go_ff        <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_start_in_div: assert property (@(posedge clock) disable iff (reset)
      cmd_o.div_start |-> (state_ff == S_CAM || state_ff == S_DX || state_ff == S_DY
                           || state_ff == S_SX || state_ff == S_SY || state_ff == S_PERP))
      else $error("divider started outside a division state");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_o.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while a transaction is pending");
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_CLEAR |=> state_ff != S_CLEAR)
      else $error("clearing pass restarted without reset");
   a_walk_has_ray: assert property (@(posedge clock) disable iff (reset)
      cmd_o.walk_step |-> !stat_i.ray_zero)
      else $error("walk step with a zero ray");
`endif
endmodule

// ===== sv/grid_ray_caster_dda_unit.sv =====
// Top level: grid ray caster with CSR block, controller and datapath.
// Cell write (kind 0): written to the map in the same cycle as its handshake, no result transaction.
// Ray cast (kind 1): five divisions on one shared divider, two setup steps (multiply, ray), each
// DDA step in the states step, check and test (up to 2*MAP_DIM steps), a result state, plus a
// distance division on a hit; one cast at a time, the next taken while a result waits.
// Synchronous reset, then a clearing pass over every map cell with req_ready low.
`timescale 1ns / 1ps
module grid_ray_caster_dda_unit #(
   parameter int MAP_DIM = grcd_pkg::MapDimDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [grcd_pkg::ColW-1:0]      req_column,
   input  logic [grcd_pkg::CellAddrW-1:0] req_cell_addr,
   input  logic                           req_cell_wall,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [grcd_pkg::DistW-1:0]     rsp_perp_dist,
   output logic                           rsp_hit_side,
   output logic [grcd_pkg::HitW-1:0]      rsp_hit_x,
   output logic [grcd_pkg::HitW-1:0]      rsp_hit_y,
   output logic                           rsp_hit_found,
   // CSR port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [grcd_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [grcd_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [grcd_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                           csr_pready
);
   localparam int DW = grcd_pkg::CsrDataW;

   // configuration registers, reset to the default view
   grcd_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_wr;
   logic [2:0]        csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            grcd_pkg::REG_POS_X:    cfg_in.pos_x   = csr_pwdata[grcd_pkg::PosW-1:0];
            grcd_pkg::REG_POS_Y:    cfg_in.pos_y   = csr_pwdata[grcd_pkg::PosW-1:0];
            grcd_pkg::REG_DIR_X:    cfg_in.dir_x   = $signed(csr_pwdata[grcd_pkg::VecW-1:0]);
            grcd_pkg::REG_DIR_Y:    cfg_in.dir_y   = $signed(csr_pwdata[grcd_pkg::VecW-1:0]);
            grcd_pkg::REG_PLANE_X:  cfg_in.plane_x = $signed(csr_pwdata[grcd_pkg::VecW-1:0]);
            grcd_pkg::REG_PLANE_Y:  cfg_in.plane_y = $signed(csr_pwdata[grcd_pkg::VecW-1:0]);
            grcd_pkg::REG_SCREEN_W: cfg_in.screen_width = csr_pwdata[grcd_pkg::SwW-1:0];
            grcd_pkg::REG_MAP_W:    cfg_in.map_width    = csr_pwdata[grcd_pkg::MwW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // read-back: signed vectors read sign-extended
   always_comb begin
      unique case (csr_idx)
         grcd_pkg::REG_POS_X:    csr_prdata = DW'(cfg_ff.pos_x);
         grcd_pkg::REG_POS_Y:    csr_prdata = DW'(cfg_ff.pos_y);
         grcd_pkg::REG_DIR_X:    csr_prdata = DW'(cfg_ff.dir_x);
         grcd_pkg::REG_DIR_Y:    csr_prdata = DW'(cfg_ff.dir_y);
         grcd_pkg::REG_PLANE_X:  csr_prdata = DW'(cfg_ff.plane_x);
         grcd_pkg::REG_PLANE_Y:  csr_prdata = DW'(cfg_ff.plane_y);
         grcd_pkg::REG_SCREEN_W: csr_prdata = DW'(cfg_ff.screen_width);
         grcd_pkg::REG_MAP_W:    csr_prdata = DW'(cfg_ff.map_width);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x        <= '0;
         cfg_ff.pos_y        <= '0;
         cfg_ff.dir_x        <= -16'sd16384;
         cfg_ff.dir_y        <= '0;
         cfg_ff.plane_x      <= '0;
         cfg_ff.plane_y      <= 16'sd10813;
         cfg_ff.screen_width <= 13'd640;
         cfg_ff.map_width    <= 7'd24;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // controller <-> datapath
   grcd_pkg::cmd_type  cmd;
   grcd_pkg::stat_type stat;

   grcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   grcd_dp #(
      .MAP_DIM (MAP_DIM)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg_i       (cfg_ff),
      .cmd_i       (cmd),
      .stat_o      (stat),
      .column_i    (req_column),
      .cell_addr_i (req_cell_addr),
      .cell_wall_i (req_cell_wall),
      .perp_dist_o (rsp_perp_dist),
      .hit_side_o  (rsp_hit_side),
      .hit_x_o     (rsp_hit_x),
      .hit_y_o     (rsp_hit_y),
      .hit_found_o (rsp_hit_found)
   );
endmodule

// ===== verif/grid_ray_caster_dda_unit_tb.sv =====
// Self-checking testbench for grid_ray_caster_dda_unit: random map writes and column casts.
`timescale 1ns / 1ps
module grid_ray_caster_dda_unit_tb;

   localparam int MapDim   = 64;
   localparam int MapCells = MapDim * MapDim;
   localparam longint unsigned CycleLimit = 5_000_000;
   localparam logic [0:0] KIND_WRITE = 1'b0;
   localparam logic [0:0] KIND_CAST  = 1'b1;

   // one request transaction
   typedef struct {
      logic                           kind;
      logic [grcd_pkg::ColW-1:0]      column;
      logic [grcd_pkg::CellAddrW-1:0] addr;
      logic                           wall;
   } req_item_type;

   // one response transaction
   typedef struct packed {
      logic [grcd_pkg::DistW-1:0] perp;
      logic                       side;
      logic [grcd_pkg::HitW-1:0]  hx;
      logic [grcd_pkg::HitW-1:0]  hy;
      logic                       found;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic req_kind = 1'b0, req_cell_wall = 1'b0;
   logic [grcd_pkg::ColW-1:0] req_column = '0;
   logic [grcd_pkg::CellAddrW-1:0] req_cell_addr = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [grcd_pkg::DistW-1:0] rsp_perp_dist;
   logic rsp_hit_side, rsp_hit_found;
   logic [grcd_pkg::HitW-1:0] rsp_hit_x, rsp_hit_y;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0, csr_pready;
   logic [grcd_pkg::CsrAddrW-1:0] csr_paddr = '0;
   logic [grcd_pkg::CsrDataW-1:0] csr_pwdata = '0, csr_prdata;

   grid_ray_caster_dda_unit #(.MAP_DIM(MapDim)) dut (.*);

   // shadow state of the block
   grcd_pkg::cfg_type cfg_shadow;
   bit           wall_shadow [MapCells];
   req_item_type pending_q [$];
   hit_type      hit_q [$];
   int        errors = 0;
   int        casts_taken = 0;
   bit        steady = 1'b0;   // phase with no idling on either side
   longint unsigned cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic longint unsigned absval(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic bit cell_inside(longint x, longint y, longint unsigned mw);
      if (x < 0 || y < 0 || longint'(x) >= longint'(mw)) return 1'b0;
      return (longint'(x) + y * longint'(mw)) < MapCells;
   endfunction

   // DDA walk from the viewer for one screen column
   function automatic hit_type trace_ray(logic [grcd_pkg::ColW-1:0] column);
      longint unsigned one, fmask, sw, ax, ay, dx, dy, sx, sy, fx, fy, px, py, mw, d;
      longint cam, rx, ry, mx, my, edge_pos, num;
      int stx, sty, side, found;
      hit_type h;
      one   = 64'd1 << grcd_pkg::FracBits;
      fmask = one - 1;
      px = cfg_shadow.pos_x;
      py = cfg_shadow.pos_y;
      mw = cfg_shadow.map_width;
      sw = (cfg_shadow.screen_width == 0) ? 1 : cfg_shadow.screen_width;
      cam = longint'((2 * longint'(column) * one) / sw) - longint'(one);
      // arithmetic shift of a signed product floors toward minus infinity
      rx = longint'(cfg_shadow.dir_x)
           + ((longint'(cfg_shadow.plane_x) * cam) >>> grcd_pkg::FracBits);
      ry = longint'(cfg_shadow.dir_y)
           + ((longint'(cfg_shadow.plane_y) * cam) >>> grcd_pkg::FracBits);
      ax = absval(rx);
      ay = absval(ry);
      mx = px >> grcd_pkg::FracBits;
      my = py >> grcd_pkg::FracBits;
      stx = rx < 0 ? -1 : 1;
      sty = ry < 0 ? -1 : 1;
      fx = rx < 0 ? (px & fmask) : one - (px & fmask);
      fy = ry < 0 ? (py & fmask) : one - (py & fmask);
      dx = ax != 0 ? (64'd1 << grcd_pkg::RecipShift) / ax : '1;
      dy = ay != 0 ? (64'd1 << grcd_pkg::RecipShift) / ay : '1;
      sx = ax != 0 ? (fx << (grcd_pkg::RecipShift - grcd_pkg::FracBits)) / ax : '1;
      sy = ay != 0 ? (fy << (grcd_pkg::RecipShift - grcd_pkg::FracBits)) / ay : '1;
      side = 0;
      found = 0;
      if (ax != 0 || ay != 0) begin
         for (int n = 0; n < 2 * MapDim; n++) begin
            if (sx < sy) begin
               sx += dx; mx += stx; side = 0;
            end else begin
               sy += dy; my += sty; side = 1;
            end
            if (!cell_inside(mx, my, mw)) break;
            if (wall_shadow[mx + my * longint'(mw)]) begin
               found = 1;
               break;
            end
         end
      end
      h = '0;
      if (found) begin
         if (side == 0) begin
            edge_pos = mx + (stx < 0 ? 1 : 0);
            num = edge_pos * longint'(one) - longint'(px);
            d = (absval(num) << grcd_pkg::VecFrac) / ax;
         end else begin
            edge_pos = my + (sty < 0 ? 1 : 0);
            num = edge_pos * longint'(one) - longint'(py);
            d = (absval(num) << grcd_pkg::VecFrac) / ay;
         end
         h.perp  = d > grcd_pkg::DistMax ? grcd_pkg::DistMax : d[grcd_pkg::DistW-1:0];
         h.side  = side[0];
         h.hx    = mx[grcd_pkg::HitW-1:0];
         h.hy    = my[grcd_pkg::HitW-1:0];
         h.found = 1'b1;
      end
      return h;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver: one transaction per handshake, random gaps unless steady
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_q.size() > 0 && (steady || $urandom_range(99) >= 31)) begin
            req_item_type it;
            it = pending_q.pop_front();
            req_valid     <= 1'b1;
            req_kind      <= it.kind;
            req_column    <= it.column;
            req_cell_addr <= it.addr;
            req_cell_wall <= it.wall;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off that backs the block up
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && casts_taken >= 200) begin
         hold_left <= 3000;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || $urandom_range(99) >= 31;
      end
   end

   // monitor: predict on request handshake, check on response handshake
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_kind == KIND_WRITE) begin
               if (req_cell_addr < MapCells) wall_shadow[req_cell_addr] = req_cell_wall;
            end else begin
               hit_q.push_back(trace_ray(req_column));
               casts_taken++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (hit_q.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               hit_type w;
               w = hit_q.pop_front();
               if (rsp_perp_dist !== w.perp) report_mismatch("perp_dist", rsp_perp_dist, w.perp);
               if (rsp_hit_side !== w.side) report_mismatch("hit_side", rsp_hit_side, w.side);
               if (rsp_hit_x !== w.hx) report_mismatch("hit_x", rsp_hit_x, w.hx);
               if (rsp_hit_y !== w.hy) report_mismatch("hit_y", rsp_hit_y, w.hy);
               if (rsp_hit_found !== w.found)
                  report_mismatch("hit_found", rsp_hit_found, w.found);
            end
         end
      end
   end

   // APB write: setup then access; shadow updated with it
   task automatic csr_write(logic [2:0] idx, logic [grcd_pkg::CsrDataW-1:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= grcd_pkg::CsrAddrW'(idx) << 2;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         grcd_pkg::REG_POS_X:    cfg_shadow.pos_x   = val[grcd_pkg::PosW-1:0];
         grcd_pkg::REG_POS_Y:    cfg_shadow.pos_y   = val[grcd_pkg::PosW-1:0];
         grcd_pkg::REG_DIR_X:    cfg_shadow.dir_x   = val[grcd_pkg::VecW-1:0];
         grcd_pkg::REG_DIR_Y:    cfg_shadow.dir_y   = val[grcd_pkg::VecW-1:0];
         grcd_pkg::REG_PLANE_X:  cfg_shadow.plane_x = val[grcd_pkg::VecW-1:0];
         grcd_pkg::REG_PLANE_Y:  cfg_shadow.plane_y = val[grcd_pkg::VecW-1:0];
         grcd_pkg::REG_SCREEN_W: cfg_shadow.screen_width = val[grcd_pkg::SwW-1:0];
         default:                cfg_shadow.map_width    = val[grcd_pkg::MwW-1:0];
      endcase
   endtask

   task automatic push_item(logic kind, logic [grcd_pkg::ColW-1:0] col,
                            logic [grcd_pkg::CellAddrW-1:0] addr, logic wall);
      req_item_type it;
      it.kind = kind; it.column = col; it.addr = addr; it.wall = wall;
      pending_q.push_back(it);
   endtask

   // wait for all transactions to drain, plus margin for a cell write in flight
   task automatic drain();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_valid || hit_q.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   // random mix: writes build walls, casts probe them
   task automatic random_phase(int count, int wall_pct);
      int mw;
      mw = (cfg_shadow.map_width == 0) ? 1 : cfg_shadow.map_width;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 40) begin
            if ($urandom_range(9) == 0)
               push_item(KIND_WRITE, $urandom, $urandom, $urandom);
            else
               push_item(KIND_WRITE, $urandom,
                         $urandom_range(mw - 1) + mw * $urandom_range(MapCells / mw - 1),
                         $urandom_range(99) < wall_pct);
         end else if ($urandom_range(4) == 0) begin
            push_item(KIND_CAST, $urandom, $urandom, $urandom);
         end else begin
            push_item(KIND_CAST,
                      $urandom_range(cfg_shadow.screen_width == 0 ? 0 :
                                     cfg_shadow.screen_width - 1), $urandom, $urandom);
         end
      end
   endtask

   // random viewer setup; position mostly within the populated area
   task automatic random_config(int mw, int sw);
      int rows;
      csr_write(grcd_pkg::REG_MAP_W, mw);
      csr_write(grcd_pkg::REG_SCREEN_W, sw);
      rows = (mw == 0) ? 1 : MapCells / mw;
      if (rows > 64) rows = 64;
      if ($urandom_range(5) == 0) begin
         csr_write(grcd_pkg::REG_POS_X, $urandom);
         csr_write(grcd_pkg::REG_POS_Y, $urandom);
      end else begin
         csr_write(grcd_pkg::REG_POS_X,
                   ($urandom_range(mw == 0 ? 0 : mw - 1) << grcd_pkg::FracBits)
                   | $urandom_range(16'hFFFF));
         csr_write(grcd_pkg::REG_POS_Y,
                   ($urandom_range(rows - 1) << grcd_pkg::FracBits) | $urandom_range(16'hFFFF));
      end
      csr_write(grcd_pkg::REG_DIR_X, $urandom);
      csr_write(grcd_pkg::REG_DIR_Y, $urandom);
      csr_write(grcd_pkg::REG_PLANE_X, $urandom_range(3) == 0 ? 0 : $urandom);
      csr_write(grcd_pkg::REG_PLANE_Y, $urandom);
   endtask

   initial begin
      cfg_shadow.pos_x        = '0;
      cfg_shadow.pos_y        = '0;
      cfg_shadow.dir_x        = -16'sd16384;
      cfg_shadow.dir_y        = '0;
      cfg_shadow.plane_x      = '0;
      cfg_shadow.plane_y      = 16'sd10813;
      cfg_shadow.screen_width = 13'd640;
      cfg_shadow.map_width    = 7'd24;
      for (int i = 0; i < MapCells; i++) wall_shadow[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: viewer at (12.5, 12.5) in a 24-wide map, walls along row 2 and column 2
      csr_write(grcd_pkg::REG_POS_X, 32'h000C8000);
      csr_write(grcd_pkg::REG_POS_Y, 32'h000C8000);
      push_item(KIND_CAST, 12'd320, '0, 1'b0);        // empty map: runs off or out of steps
      for (int k = 0; k < 24; k++) begin
         push_item(KIND_WRITE, '0, 12'(k + 2 * 24), 1'b1);
         push_item(KIND_WRITE, '0, 12'(2 + k * 24), 1'b1);
      end
      push_item(KIND_WRITE, '0, 12'hFFF, 1'b1);        // last cell of the map
      push_item(KIND_WRITE, '0, 12'(2 + 12 * 24), 1'b0); // clear one wall again
      push_item(KIND_CAST, 12'd0, 12'hFFF, 1'b1);
      push_item(KIND_CAST, 12'd639, '0, 1'b0);
      push_item(KIND_CAST, 12'd320, '0, 1'b0);
      push_item(KIND_CAST, 12'hFFF, '0, 1'b0);          // beyond screen width
      drain();

      // zero ray, then one axis only
      csr_write(grcd_pkg::REG_DIR_X, '0);
      csr_write(grcd_pkg::REG_PLANE_Y, '0);
      push_item(KIND_CAST, 12'd100, '0, 1'b0);
      drain();
      csr_write(grcd_pkg::REG_DIR_Y, 32'hFFFF8000);    // most negative vector
      push_item(KIND_CAST, 12'd5, '0, 1'b0);
      drain();
      csr_write(grcd_pkg::REG_DIR_Y, 32'h7FFF);
      csr_write(grcd_pkg::REG_PLANE_X, 32'h7FFF);
      csr_write(grcd_pkg::REG_SCREEN_W, '0);            // zero width acts as one
      push_item(KIND_CAST, 12'd0, '0, 1'b0);
      push_item(KIND_CAST, 12'd1, '0, 1'b0);
      drain();
      csr_write(grcd_pkg::REG_MAP_W, '0);               // nothing inside the map
      push_item(KIND_CAST, 12'd0, '0, 1'b0);
      drain();

      // random phases over several settings, extremes included
      for (int ph = 0; ph < 12; ph++) begin
         int mw, sw;
         case (ph)
            0:       begin mw = 64;  sw = 4096; end
            1:       begin mw = 1;   sw = 1;    end
            2:       begin mw = 127; sw = 8191; end
            3:       begin mw = 0;   sw = 640;  end
            default: begin mw = $urandom_range(2, 64); sw = $urandom_range(1, 1024); end
         endcase
         steady = (ph == 5);
         random_config(mw, sw);
         random_phase(100, ph < 6 ? 25 : 8);
         drain();
      end
      steady = 1'b0;

      repeat (400) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
